/* hdl/aou_pkg.sv */
package aou_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;
  localparam logic [31:0] FP_ONE    = 32'h3F800000;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND   = 3'd5;

  localparam logic [31:0] RST_LEARNING_RATE = 32'd981668463;
  localparam logic [31:0] RST_BETA_ONE      = 32'd1063675494;
  localparam logic [31:0] RST_BETA_TWO      = 32'd1065336439;
  localparam logic [31:0] RST_EPSILON       = 32'd841731191;
  localparam logic [31:0] RST_LOWER_BOUND   = 32'd4286578687;
  localparam logic [31:0] RST_UPPER_BOUND   = 32'd2139095039;

  // recurrence steps done per pipeline stage in the divider and root units
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_QBITS   = 28;
  localparam int DIV_STAGES  = DIV_QBITS / STEPS_PER_STAGE;
  localparam int DIV_LAT     = DIV_STAGES + 2;
  localparam int SQRT_RBITS  = 28;
  localparam int SQRT_STAGES = SQRT_RBITS / STEPS_PER_STAGE;
  localparam int SQRT_LAT    = SQRT_STAGES + 2;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] m2;
    logic [31:0] v2;
    logic [31:0] p1b1;
    logic [31:0] p2b2;
    logic [31:0] aux;
    logic        last;
  } ctx_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spv;
    logic               s;
    logic signed [11:0] e;
    logic [23:0]        mb;
    logic [25:0]        r;
    logic [27:0]        q;
  } div_st_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spv;
    logic signed [11:0] e;
    logic [55:0]        n;
    logic [30:0]        rem;
    logic [27:0]        root;
  } sqrt_st_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return !(|x[30:0]);
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] x);
    return is_nan(x) ? CANON_NAN : x;
  endfunction

  function automatic logic [6:0] clz64(input logic [63:0] x);
    logic [6:0] lz;
    lz = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) lz = 7'(63 - i);
    end
    return lz;
  endfunction

  function automatic logic [63:0] shr_jam(input logic [63:0] x, input logic [8:0] d);
    logic [63:0] msk;
    logic        lost;
    if (d > 9'd63) return {63'b0, |x};
    msk  = ~({64{1'b1}} << d[5:0]);
    lost = |(x & msk);
    return (x >> d[5:0]) | {63'b0, lost};
  endfunction

  // value = sig * 2^(e - 127 - 63); normalize, round to nearest even, pack
  function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                           input logic [63:0] sig);
    logic [6:0]         lz;
    logic [63:0]        nm;
    logic signed [12:0] en;
    logic [12:0]        sh;
    logic [63:0]        msk;
    logic               lost;
    logic [10:0]        eb;
    logic [23:0]        top;
    logic               g;
    logic               st;
    logic               inc;
    logic [33:0]        tot;
    if (sig == '0) return {s, 31'b0};
    lz = clz64(sig);
    nm = sig << lz;
    en = 13'(e) - 13'(lz);
    if (en < 13'sd1) begin
      sh = 13'(13'sd1 - en);
      if (sh > 13'd63) sh = 13'd63;
      msk  = ~({64{1'b1}} << sh[5:0]);
      lost = |(nm & msk);
      nm   = (nm >> sh[5:0]) | {63'b0, lost};
      eb   = 11'd0;
    end else begin
      eb = 11'(en - 13'sd1);
    end
    top = nm[63:40];
    g   = nm[39];
    st  = |nm[38:0];
    inc = g & (st | top[0]);
    tot = {eb, 23'b0} + 34'(top) + 34'(inc);
    if (tot >= 34'(32'h7F800000)) return {s, 8'hFF, 23'b0};
    return {s, tot[30:0]};
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [8:0]  ea;
    logic [8:0]  eb;
    logic [63:0] sa_v;
    logic [63:0] sb_v;
    logic [63:0] big;
    logic [63:0] sml;
    logic [63:0] r;
    logic [8:0]  ex;
    logic        sbig;
    logic        ssml;
    logic        s;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    ea   = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb   = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    sa_v = {1'b0, (a[30:23] != 8'd0), a[22:0], 39'b0};
    sb_v = {1'b0, (b[30:23] != 8'd0), b[22:0], 39'b0};
    if (ea >= eb) begin
      big = sa_v; sml = shr_jam(sb_v, ea - eb); ex = ea; sbig = a[31]; ssml = b[31];
    end else begin
      big = sb_v; sml = shr_jam(sa_v, eb - ea); ex = eb; sbig = b[31]; ssml = a[31];
    end
    if (sbig == ssml) begin
      r = big + sml; s = sbig;
    end else if (big >= sml) begin
      r = big - sml; s = sbig;
    end else begin
      r = sml - big; s = ssml;
    end
    if (r == '0) return {a[31] & b[31], 31'b0};
    return fp_round(s, 12'(ex) + 12'sd1, r);
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [8:0]         ea;
    logic [8:0]         eb;
    logic [47:0]        p;
    logic signed [11:0] e;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return CANON_NAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'b0};
    if (is_zero(a) || is_zero(b)) return {s, 31'b0};
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    p  = {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
    e  = 12'(ea) + 12'(eb) - 12'sd126;
    return fp_round(s, e, {p, 16'b0});
  endfunction

  // a < b, false when either is NaN, zeros of both signs equal
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (is_zero(a) && is_zero(b)) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  function automatic div_st_t div_pre(input logic [31:0] a, input logic [31:0] b);
    div_st_t     st;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [6:0]  lza;
    logic [6:0]  lzb;
    logic [8:0]  ea;
    logic [8:0]  eb;
    st      = '0;
    st.s    = a[31] ^ b[31];
    st.spec = 1'b1;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b)))
      st.spv = CANON_NAN;
    else if (is_inf(a) || is_zero(b))
      st.spv = {st.s, 8'hFF, 23'b0};
    else if (is_zero(a) || is_inf(b))
      st.spv = {st.s, 31'b0};
    else
      st.spec = 1'b0;
    ma   = {(a[30:23] != 8'd0), a[22:0]};
    mb   = {(b[30:23] != 8'd0), b[22:0]};
    lza  = clz64({ma, 40'b0});
    lzb  = clz64({mb, 40'b0});
    ea   = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb   = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    st.e = 12'(ea) - 12'(lza) - 12'(eb) + 12'(lzb) + 12'sd127;
    st.mb = mb << lzb[4:0];
    st.r  = 26'(ma << lza[4:0]);
    st.q  = '0;
    return st;
  endfunction

  function automatic div_st_t div_iter(input div_st_t si);
    div_st_t st;
    logic    ge;
    st = si;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      ge   = st.r >= 26'(st.mb);
      st.q = {st.q[26:0], ge};
      st.r = (ge ? (st.r - 26'(st.mb)) : st.r) << 1;
    end
    return st;
  endfunction

  function automatic logic [31:0] div_post(input div_st_t st);
    if (st.spec) return st.spv;
    return fp_round(st.s, st.e, {st.q, 35'b0, (st.r != '0)});
  endfunction

  function automatic sqrt_st_t sqrt_pre(input logic [31:0] x);
    sqrt_st_t           st;
    logic [23:0]        ma;
    logic [6:0]         lz;
    logic [8:0]         ex;
    logic signed [11:0] ef;
    logic [24:0]        m2;
    st      = '0;
    st.spec = 1'b1;
    if (is_nan(x))       st.spv = CANON_NAN;
    else if (is_zero(x)) st.spv = x;
    else if (x[31])      st.spv = CANON_NAN;
    else if (is_inf(x))  st.spv = x;
    else                 st.spec = 1'b0;
    ma = {(x[30:23] != 8'd0), x[22:0]};
    lz = clz64({ma, 40'b0});
    ma = ma << lz[4:0];
    ex = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
    ef = 12'(ex) - 12'(lz) - 12'sd127;
    m2 = ef[0] ? {ma, 1'b0} : {1'b0, ma};
    if (ef[0]) ef = ef - 12'sd1;
    st.n    = {6'b0, m2, 25'b0};
    st.e    = (ef >>> 1) + 12'sd130;
    st.rem  = '0;
    st.root = '0;
    return st;
  endfunction

  function automatic sqrt_st_t sqrt_iter(input sqrt_st_t si);
    sqrt_st_t    st;
    logic [30:0] trial;
    st = si;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      st.rem = {st.rem[28:0], st.n[55:54]};
      st.n   = st.n << 2;
      trial  = {1'b0, st.root, 2'b01};
      if (st.rem >= trial) begin
        st.rem  = st.rem - trial;
        st.root = {st.root[26:0], 1'b1};
      end else begin
        st.root = {st.root[26:0], 1'b0};
      end
    end
    return st;
  endfunction

  function automatic logic [31:0] sqrt_post(input sqrt_st_t st);
    if (st.spec) return st.spv;
    return fp_round(1'b0, st.e, {st.root, 35'b0, (st.rem != '0)});
  endfunction

endpackage

/* hdl/aou_div.sv */
module aou_div
  import aou_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  div_st_t     st_r [DIV_STAGES+1];
  logic [31:0] y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_pre(a, b);
      for (int k = 1; k <= DIV_STAGES; k++) st_r[k] <= div_iter(st_r[k-1]);
      y_r <= div_post(st_r[DIV_STAGES]);
    end
  end

  assign y = y_r;

endmodule

/* hdl/aou_sqrt.sv */
module aou_sqrt
  import aou_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  output logic [31:0] y
);

  sqrt_st_t    st_r [SQRT_STAGES+1];
  logic [31:0] y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= sqrt_pre(x);
      for (int k = 1; k <= SQRT_STAGES; k++) st_r[k] <= sqrt_iter(st_r[k-1]);
      y_r <= sqrt_post(st_r[SQRT_STAGES]);
    end
  end

  assign y = y_r;

endmodule

/* hdl/adam_optimizer_update_top.sv */
// Throughput: one transaction per cycle; the pipeline holds as a whole while out_stall
//   is high and a result waits. Depth is set by the root and divide units (9 each).
// Reset (rst_n low, synchronous) clears all valid bits and loads default registers;
//   data registers are not reset.
module adam_optimizer_update_top
  import aou_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_weight,
  input  logic [31:0]          in_first_moment,
  input  logic [31:0]          in_second_moment,
  input  logic [31:0]          in_gradient,
  input  logic [31:0]          in_beta_one_power,
  input  logic [31:0]          in_beta_two_power,
  input  logic                 in_last_of_vector,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_new_weight,
  output logic [31:0]          out_new_first_moment,
  output logic [31:0]          out_new_second_moment,
  output logic [31:0]          out_new_beta_one_power,
  output logic [31:0]          out_new_beta_two_power,
  output logic                 out_vector_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int PIPE_DEPTH = 4 + SQRT_LAT + 1 + DIV_LAT + 4;

  typedef struct packed {
    logic [31:0] w, g, t1, t2, b1m, omb1, b2v, omb2, p1b1, p2b2;
    logic        last;
  } s1_t;

  typedef struct packed {
    logic [31:0] w, g, t1, t2, b1m, g1, b2v, g2, p1b1, p2b2;
    logic        last;
  } s2_t;

  typedef struct packed {
    logic [31:0] w, t1, t2, m2, b2v, g2g, p1b1, p2b2;
    logic        last;
  } s3_t;

  logic [31:0] lr_r, b1_r, b2_r, eps_r, lo_r, hi_r;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  en;

  s1_t         s1_r;
  s2_t         s2_r;
  s3_t         s3_r;
  ctx_t        s4_ctx_r;
  logic [31:0] s4_t1_r;
  ctx_t        sq_ctx_r [SQRT_LAT];
  logic [31:0] sq_t1;
  logic [31:0] sq_v2;
  ctx_t        s14_ctx_r;
  logic [31:0] s14_rt1_r;
  logic [31:0] s14_den_r;
  ctx_t        dv_ctx_r [DIV_LAT];
  logic [31:0] dv_step;
  logic [31:0] dv_q;
  ctx_t        s24_ctx_r;
  logic [31:0] s24_step_r;
  logic [31:0] s24_q_r;
  ctx_t        s25_ctx_r;
  logic [31:0] s25_qq_r;
  ctx_t        s26_ctx_r;
  logic [31:0] s26_nw_r;
  logic [31:0] clamp_lo;
  logic [31:0] clamp_nxt;
  logic [31:0] o_w_r, o_m_r, o_v_r, o_p1_r, o_p2_r;
  logic        o_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= RST_LEARNING_RATE;
      b1_r  <= RST_BETA_ONE;
      b2_r  <= RST_BETA_TWO;
      eps_r <= RST_EPSILON;
      lo_r  <= RST_LOWER_BOUND;
      hi_r  <= RST_UPPER_BOUND;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEARNING_RATE: lr_r  <= cfg_data;
        CFG_BETA_ONE:      b1_r  <= cfg_data;
        CFG_BETA_TWO:      b2_r  <= cfg_data;
        CFG_EPSILON:       eps_r <= cfg_data;
        CFG_LOWER_BOUND:   lo_r  <= cfg_data;
        CFG_UPPER_BOUND:   hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output holds a result that is not taken
  assign en       = !vld_r[PIPE_DEPTH-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.w    <= in_weight;
      s1_r.g    <= in_gradient;
      s1_r.t1   <= fp_sub(FP_ONE, in_beta_two_power);
      s1_r.t2   <= fp_sub(FP_ONE, in_beta_one_power);
      s1_r.b1m  <= fp_mul(b1_r, in_first_moment);
      s1_r.omb1 <= fp_sub(FP_ONE, b1_r);
      s1_r.b2v  <= fp_mul(b2_r, in_second_moment);
      s1_r.omb2 <= fp_sub(FP_ONE, b2_r);
      s1_r.p1b1 <= fp_mul(in_beta_one_power, b1_r);
      s1_r.p2b2 <= fp_mul(in_beta_two_power, b2_r);
      s1_r.last <= in_last_of_vector;

      s2_r.w    <= s1_r.w;
      s2_r.g    <= s1_r.g;
      s2_r.t1   <= s1_r.t1;
      s2_r.t2   <= s1_r.t2;
      s2_r.b1m  <= s1_r.b1m;
      s2_r.g1   <= fp_mul(s1_r.omb1, s1_r.g);
      s2_r.b2v  <= s1_r.b2v;
      s2_r.g2   <= fp_mul(s1_r.omb2, s1_r.g);
      s2_r.p1b1 <= s1_r.p1b1;
      s2_r.p2b2 <= s1_r.p2b2;
      s2_r.last <= s1_r.last;

      s3_r.w    <= s2_r.w;
      s3_r.t1   <= s2_r.t1;
      s3_r.t2   <= s2_r.t2;
      s3_r.m2   <= fp_add(s2_r.b1m, s2_r.g1);
      s3_r.b2v  <= s2_r.b2v;
      s3_r.g2g  <= fp_mul(s2_r.g2, s2_r.g);
      s3_r.p1b1 <= s2_r.p1b1;
      s3_r.p2b2 <= s2_r.p2b2;
      s3_r.last <= s2_r.last;

      s4_ctx_r.w    <= s3_r.w;
      s4_ctx_r.m2   <= s3_r.m2;
      s4_ctx_r.v2   <= fp_add(s3_r.b2v, s3_r.g2g);
      s4_ctx_r.p1b1 <= s3_r.p1b1;
      s4_ctx_r.p2b2 <= s3_r.p2b2;
      s4_ctx_r.aux  <= s3_r.t2;
      s4_ctx_r.last <= s3_r.last;
      s4_t1_r       <= s3_r.t1;

      sq_ctx_r[0] <= s4_ctx_r;
      for (int k = 1; k < SQRT_LAT; k++) sq_ctx_r[k] <= sq_ctx_r[k-1];

      s14_ctx_r <= sq_ctx_r[SQRT_LAT-1];
      s14_rt1_r <= sq_t1;
      s14_den_r <= fp_add(sq_v2, eps_r);

      dv_ctx_r[0] <= s14_ctx_r;
      for (int k = 1; k < DIV_LAT; k++) dv_ctx_r[k] <= dv_ctx_r[k-1];

      s24_ctx_r  <= dv_ctx_r[DIV_LAT-1];
      s24_step_r <= fp_mul(lr_r, dv_step);
      s24_q_r    <= dv_q;

      s25_ctx_r <= s24_ctx_r;
      s25_qq_r  <= fp_mul(s24_step_r, s24_q_r);

      s26_ctx_r <= s25_ctx_r;
      s26_nw_r  <= fp_sub(s25_ctx_r.w, s25_qq_r);

      o_w_r    <= canon(clamp_nxt);
      o_m_r    <= canon(s26_ctx_r.m2);
      o_v_r    <= canon(s26_ctx_r.v2);
      o_p1_r   <= canon(s26_ctx_r.p1b1);
      o_p2_r   <= canon(s26_ctx_r.p2b2);
      o_last_r <= s26_ctx_r.last;
    end
  end

  aou_sqrt u_sqrt_t1 (.clk(clk), .en(en), .x(s4_t1_r),     .y(sq_t1));
  aou_sqrt u_sqrt_v2 (.clk(clk), .en(en), .x(s4_ctx_r.v2), .y(sq_v2));

  // sqrt(1 - beta2pow) / (1 - beta1pow), and m' / (sqrt(v') + eps)
  aou_div u_div_step (.clk(clk), .en(en), .a(s14_rt1_r),    .b(s14_ctx_r.aux), .y(dv_step));
  aou_div u_div_q    (.clk(clk), .en(en), .a(s14_ctx_r.m2), .b(s14_den_r),     .y(dv_q));

  // lower bound first, then upper; a NaN weight fails both compares
  always_comb begin
    clamp_lo  = fp_lt(s26_nw_r, lo_r) ? lo_r : s26_nw_r;
    clamp_nxt = fp_lt(hi_r, clamp_lo) ? hi_r : clamp_lo;
  end

  assign out_valid              = vld_r[PIPE_DEPTH-1];
  assign out_new_weight         = o_w_r;
  assign out_new_first_moment   = o_m_r;
  assign out_new_second_moment  = o_v_r;
  assign out_new_beta_one_power = o_p1_r;
  assign out_new_beta_two_power = o_p2_r;
  assign out_vector_done        = o_last_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && vld_r[PIPE_DEPTH-2]) |=> out_valid)
    else $error("result lost before the output register");

endmodule
